### hw/rtl/cgbc_pkg.sv
// Package for the box-centered curl block: widths, fixed-point constants,
// register indexes, datapath operation codes and controller/datapath structs.
// Depends on nothing.
`default_nettype none

package cgbc_pkg;

  localparam int unsigned MAX_ROWS   = 1024;
  localparam int unsigned MAX_COLS   = 65536;
  localparam int unsigned ROW_W      = $clog2(MAX_ROWS);
  localparam int unsigned COL_W      = $clog2(MAX_COLS);
  localparam int unsigned ROWS_CFG_W = 11;
  localparam int unsigned COLS_CFG_W = 17;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned LINE_W     = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_GEO  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd2;

  localparam logic [34:0] PI_Q40      = 35'd19190098069;
  localparam logic [32:0] METRES_K    = 33'd7287270713;
  localparam logic [30:0] DEG_FULL    = 31'd1509949440;
  localparam logic [30:0] DEG_HALF    = 31'd754974720;
  localparam logic [30:0] DEG_QUARTER = 31'd377487360;
  localparam logic [30:0] ONE_Q30     = 31'd1073741824;

  localparam int unsigned DIV_W       = 128;
  localparam int unsigned DIV_CNT_W   = 8;
  localparam logic [DIV_CNT_W-1:0] TERM_STEPS   = 8'd128;
  localparam logic [2:0] SERIES_TOP   = 3'd7;
  localparam int unsigned SH_PLAIN    = 45;
  localparam int unsigned SH_GEO_V    = 92;
  localparam int unsigned SH_GEO_U    = 61;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_REDUCE,
    OP_FOLD,
    OP_MUL_T,
    OP_MUL_X,
    OP_MUL_H,
    OP_DIV_H,
    OP_SET_H,
    OP_EVAL,
    OP_SCALE1,
    OP_SCALE2,
    OP_SCALE3,
    OP_SCALE4,
    OP_DIV_SV,
    OP_TERM_SV,
    OP_DIV_SU,
    OP_TERM_SU,
    OP_DIFF,
    OP_EMIT,
    OP_COMMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic has_result;
    logic zero;
    logic geo;
    logic div_done;
    logic series_last;
    logic out_free;
  } status_t;

  // Reciprocal ceil(2^s/d) of the series divisor d = (2k-1)(2k); the product with any
  // 32-bit value, shifted right by s, is the exact truncated quotient.
  function automatic logic [32:0] series_recip(input logic [2:0] k);
    logic [32:0] m;
    case (k)
      3'd7: m = 33'd6041272681;
      3'd6: m = 33'd8329633544;
      3'd5: m = 33'd6108397933;
      3'd4: m = 33'd4908534053;
      3'd3: m = 33'd4581298450;
      3'd2: m = 33'd5726623062;
      3'd1: m = 33'd4294967296;
      default: m = 33'd4294967296;
    endcase
    return m;
  endfunction

  function automatic logic [5:0] series_shift(input logic [2:0] k);
    logic [5:0] s;
    case (k)
      3'd7: s = 6'd40;
      3'd6: s = 6'd40;
      3'd5: s = 6'd39;
      3'd4: s = 6'd38;
      3'd3: s = 6'd37;
      3'd2: s = 6'd36;
      3'd1: s = 6'd33;
      default: s = 6'd32;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/cgbc_intf.sv
// Channel interfaces of the curl block: grid point input, result output and
// configuration write. Depends on cgbc_pkg.
`default_nettype none

interface cgbc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] u_value;
  logic signed [31:0] v_value;
  logic signed [31:0] x_coord;
  logic signed [31:0] y_coord;
  modport source (output valid, u_value, v_value, x_coord, y_coord, input ready);
  modport sink (input valid, u_value, v_value, x_coord, y_coord, output ready);
endinterface

interface cgbc_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] curl_value;
  logic signed [31:0] x_mid;
  logic signed [31:0] y_mid;
  logic               zero_spacing;
  logic               saturated;
  logic               last_of_grid;
  modport source (output valid, curl_value, x_mid, y_mid, zero_spacing, saturated,
                  last_of_grid, input ready);
  modport sink (input valid, curl_value, x_mid, y_mid, zero_spacing, saturated,
                last_of_grid, output ready);
endinterface

interface cgbc_cfg_if;
  import cgbc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/cgbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module cgbc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/cgbc_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, shared by the
// two curl terms. Depends on cgbc_pkg.
`default_nettype none

module cgbc_div (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire logic [cgbc_pkg::DIV_CNT_W-1:0] count_i,
  input  wire logic [cgbc_pkg::DIV_W-1:0] num_i,
  input  wire logic [cgbc_pkg::DIV_W-1:0] den_i,
  output logic done_o,
  output logic [cgbc_pkg::DIV_W-1:0] quot_o
);
  import cgbc_pkg::*;

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]     num_q, rem_q, den_q;
  logic [DIV_W:0]       rem_sh, rem_sub;
  logic                 ge;

  always_comb begin
    rem_sh  = {rem_q, num_q[DIV_W-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    ge      = rem_sh >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= count_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[DIV_W-2:0], ge};
      rem_q <= ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

`default_nettype wire

### hw/rtl/cgbc_ctrl.sv
// Controller of the curl block: sequences the datapath through one grid point
// at a time and owns the input handshake. Depends on cgbc_pkg.
`default_nettype none

module cgbc_ctrl (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire cgbc_pkg::status_t status_i,
  output cgbc_pkg::cmd_t cmd_o
);
  import cgbc_pkg::*;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_REDUCE  = 5'd1;
  localparam logic [4:0] S_FOLD    = 5'd2;
  localparam logic [4:0] S_MUL_T   = 5'd3;
  localparam logic [4:0] S_MUL_X   = 5'd4;
  localparam logic [4:0] S_MUL_H   = 5'd5;
  localparam logic [4:0] S_DIV_H   = 5'd6;
  localparam logic [4:0] S_SET_H   = 5'd8;
  localparam logic [4:0] S_EVAL    = 5'd9;
  localparam logic [4:0] S_BRANCH  = 5'd10;
  localparam logic [4:0] S_SCALE1  = 5'd11;
  localparam logic [4:0] S_SCALE2  = 5'd12;
  localparam logic [4:0] S_SCALE3  = 5'd13;
  localparam logic [4:0] S_SCALE4  = 5'd14;
  localparam logic [4:0] S_DIV_SV  = 5'd15;
  localparam logic [4:0] S_WAIT_SV = 5'd16;
  localparam logic [4:0] S_TERM_SV = 5'd17;
  localparam logic [4:0] S_DIV_SU  = 5'd18;
  localparam logic [4:0] S_WAIT_SU = 5'd19;
  localparam logic [4:0] S_TERM_SU = 5'd20;
  localparam logic [4:0] S_DIFF    = 5'd21;
  localparam logic [4:0] S_EMIT    = 5'd22;

  logic [4:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    in_ready_o = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_REDUCE;
        end
      end
      S_REDUCE: begin
        cmd_o.op = OP_REDUCE;
        state_d  = S_FOLD;
      end
      S_FOLD: begin
        cmd_o.op = OP_FOLD;
        state_d  = S_MUL_T;
      end
      S_MUL_T: begin
        cmd_o.op = OP_MUL_T;
        state_d  = S_MUL_X;
      end
      S_MUL_X: begin
        cmd_o.op = OP_MUL_X;
        state_d  = S_MUL_H;
      end
      S_MUL_H: begin
        cmd_o.op = OP_MUL_H;
        state_d  = S_DIV_H;
      end
      S_DIV_H: begin
        cmd_o.op = OP_DIV_H;
        state_d  = S_SET_H;
      end
      S_SET_H: begin
        cmd_o.op = OP_SET_H;
        state_d  = status_i.series_last ? S_EVAL : S_MUL_H;
      end
      S_EVAL: begin
        cmd_o.op = OP_EVAL;
        state_d  = S_BRANCH;
      end
      S_BRANCH: begin
        if (!status_i.has_result || status_i.zero) begin
          state_d = S_EMIT;
        end else if (status_i.geo) begin
          state_d = S_SCALE1;
        end else begin
          state_d = S_DIV_SV;
        end
      end
      S_SCALE1: begin
        cmd_o.op = OP_SCALE1;
        state_d  = S_SCALE2;
      end
      S_SCALE2: begin
        cmd_o.op = OP_SCALE2;
        state_d  = S_SCALE3;
      end
      S_SCALE3: begin
        cmd_o.op = OP_SCALE3;
        state_d  = S_SCALE4;
      end
      S_SCALE4: begin
        cmd_o.op = OP_SCALE4;
        state_d  = S_DIV_SV;
      end
      S_DIV_SV: begin
        cmd_o.op = OP_DIV_SV;
        state_d  = S_WAIT_SV;
      end
      S_WAIT_SV: begin
        if (status_i.div_done) begin
          state_d = S_TERM_SV;
        end
      end
      S_TERM_SV: begin
        cmd_o.op = OP_TERM_SV;
        state_d  = S_DIV_SU;
      end
      S_DIV_SU: begin
        cmd_o.op = OP_DIV_SU;
        state_d  = S_WAIT_SU;
      end
      S_WAIT_SU: begin
        if (status_i.div_done) begin
          state_d = S_TERM_SU;
        end
      end
      S_TERM_SU: begin
        cmd_o.op = OP_TERM_SU;
        state_d  = S_DIFF;
      end
      S_DIFF: begin
        cmd_o.op = OP_DIFF;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        if (!status_i.has_result) begin
          cmd_o.op = OP_COMMIT;
          state_d  = S_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.op = OP_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/cgbc_dp.sv
// Datapath of the curl block: configuration registers, grid counters, line
// buffer, cosine series, curl terms and output register.
// Depends on cgbc_pkg, cgbc_ram and cgbc_div.
`default_nettype none

module cgbc_dp (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cgbc_pkg::cmd_t cmd_i,
  output cgbc_pkg::status_t status_o,
  input  wire logic signed [31:0] u_value_i,
  input  wire logic signed [31:0] v_value_i,
  input  wire logic signed [31:0] x_coord_i,
  input  wire logic signed [31:0] y_coord_i,
  input  wire logic cfg_valid_i,
  input  wire logic [cgbc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [cgbc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic out_valid_o,
  input  wire logic out_ready_i,
  output logic signed [63:0] curl_value_o,
  output logic signed [31:0] x_mid_o,
  output logic signed [31:0] y_mid_o,
  output logic zero_spacing_o,
  output logic saturated_o,
  output logic last_of_grid_o
);
  import cgbc_pkg::*;

  logic                  geo_q;
  logic [ROWS_CFG_W-1:0] rows_cfg_q, rows_eff;
  logic [COLS_CFG_W-1:0] cols_cfg_q, cols_eff;
  logic [ROW_W-1:0]      row_q, r_eff, r_q;
  logic [COL_W-1:0]      col_q;
  logic signed [31:0]    above_u_q, above_v_q, above_x_q, left_u_q, left_v_q;
  logic signed [31:0]    prior_y_q, prior_cos_q;
  logic signed [31:0]    u_q, v_q, x_q, y_q, old_u, old_v;
  logic                  has_res_q, last_q;
  logic [LINE_W-1:0]     rdata;
  logic                  commit;

  logic [30:0]        ang_q, ang_fold1;
  logic               neg_q;
  logic signed [32:0] ang_s, full_s;
  logic [30:0]        ang_red;
  logic [63:0]        t_prod;
  logic [61:0]        x_prod;
  logic [62:0]        h_prod;
  logic [64:0]        hq_prod;
  logic [30:0]        t_q, h_q;
  logic [31:0]        xs_q, p_q, hq_q;
  logic [2:0]         k_q;
  logic signed [31:0] cos_q, cos_cur;

  logic signed [33:0] su_c, sv_c, su_q, sv_q;
  logic signed [32:0] dx_c, dy_c, csum_c, hx_c, hy_c;
  logic [32:0]        mdx_q, mdy_q;
  logic [31:0]        mc_q;
  logic [33:0]        msv, msu;
  logic               dxneg_q, dyneg_q, zero_q;
  logic [65:0]        p1_q;
  logic [DIV_W-1:0]   den_x_q, den_y_q;

  logic               div_start, div_done;
  logic [DIV_CNT_W-1:0] div_count;
  logic [DIV_W-1:0]   div_num, div_den, div_quot;

  logic               tneg, tsat, dovf;
  logic [63:0]        tmag, tlim, tcl, tval, diff;
  logic [63:0]        t1_q, t2_q, curl_q;
  logic               sat_q;
  logic signed [31:0] xmid_q, ymid_q;

  logic               out_valid_q, zero_o_q, sat_o_q, last_o_q;
  logic signed [63:0] curl_o_q;
  logic signed [31:0] xmid_o_q, ymid_o_q;

  always_comb begin
    if (rows_cfg_q < ROWS_CFG_W'(2)) begin
      rows_eff = ROWS_CFG_W'(2);
    end else if (rows_cfg_q > ROWS_CFG_W'(MAX_ROWS)) begin
      rows_eff = ROWS_CFG_W'(MAX_ROWS);
    end else begin
      rows_eff = rows_cfg_q;
    end
    if (cols_cfg_q < COLS_CFG_W'(2)) begin
      cols_eff = COLS_CFG_W'(2);
    end else if (cols_cfg_q > COLS_CFG_W'(MAX_COLS)) begin
      cols_eff = COLS_CFG_W'(MAX_COLS);
    end else begin
      cols_eff = cols_cfg_q;
    end
    r_eff = ({1'b0, row_q} >= rows_eff) ? '0 : row_q;
  end

  assign commit = (cmd_i.op == OP_EMIT) || (cmd_i.op == OP_COMMIT);

  cgbc_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_ROWS)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (commit),
    .waddr_i (r_q),
    .wdata_i ({u_q, v_q}),
    .re_i    (cmd_i.op == OP_LOAD),
    .raddr_i (r_eff),
    .rdata_o (rdata)
  );

  assign old_u = rdata[63:32];
  assign old_v = rdata[31:0];

  // Angle reduction to [0, 360) degrees and fold to [0, 90] with a sign.
  always_comb begin
    ang_s  = 33'(y_q);
    full_s = $signed({2'b00, DEG_FULL});
    if (ang_s >= full_s) begin
      ang_red = 31'(ang_s - full_s);
    end else if (ang_s >= 0) begin
      ang_red = ang_s[30:0];
    end else if (ang_s + full_s >= 0) begin
      ang_red = 31'(ang_s + full_s);
    end else begin
      ang_red = 31'(ang_s + full_s + full_s);
    end
    ang_fold1 = (ang_q > DEG_HALF) ? DEG_FULL - ang_q : ang_q;
    t_prod    = 64'(ang_q[28:0]) * 64'(PI_Q40);
    x_prod    = 62'(t_q) * 62'(t_q);
    h_prod    = 63'(xs_q) * 63'(h_q);
    hq_prod   = 65'(p_q) * 65'(series_recip(k_q));
    cos_cur   = neg_q ? -$signed({1'b0, h_q}) : $signed({1'b0, h_q});
  end

  always_comb begin
    su_c   = (34'(above_u_q) + 34'(u_q)) - (34'(left_u_q) + 34'(old_u));
    sv_c   = (34'(old_v) + 34'(v_q)) - (34'(left_v_q) + 34'(above_v_q));
    dx_c   = 33'(x_q) - 33'(above_x_q);
    dy_c   = 33'(y_q) - 33'(prior_y_q);
    csum_c = 33'(prior_cos_q) + 33'(cos_cur);
    hx_c   = 33'(above_x_q) + 33'(x_q);
    hy_c   = 33'(prior_y_q) + 33'(y_q);
    msv    = sv_q[33] ? 34'(-sv_q) : 34'(sv_q);
    msu    = su_q[33] ? 34'(-su_q) : 34'(su_q);
  end

  always_comb begin
    div_start = 1'b0;
    div_count = TERM_STEPS;
    div_num   = DIV_W'(msv) << (geo_q ? SH_GEO_V : SH_PLAIN);
    div_den   = den_x_q;
    case (cmd_i.op)
      OP_DIV_SV: begin
        div_start = 1'b1;
      end
      OP_DIV_SU: begin
        div_start = 1'b1;
        div_num   = DIV_W'(msu) << (geo_q ? SH_GEO_U : SH_PLAIN);
        div_den   = den_y_q;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  cgbc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .count_i (div_count),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Clamp and sign of one curl term from the unsigned quotient.
  always_comb begin
    tneg = (cmd_i.op == OP_TERM_SU) ? (su_q[33] ^ dyneg_q) : (sv_q[33] ^ dxneg_q);
    tmag = div_quot[63:0];
    tlim = tneg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    tsat = (|div_quot[DIV_W-1:64]) || (tmag > tlim);
    tcl  = tsat ? tlim : tmag;
    tval = tneg ? 64'(-tcl) : tcl;
    diff = t1_q - t2_q;
    dovf = ((t1_q ^ t2_q) & (t1_q ^ diff)) >> 63 != 64'd0;
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        u_q       <= u_value_i;
        v_q       <= v_value_i;
        x_q       <= x_coord_i;
        y_q       <= y_coord_i;
        r_q       <= r_eff;
        has_res_q <= (r_eff != '0) && (col_q != '0);
        last_q    <= ({1'b0, r_eff} == rows_eff - 1'b1)
                  && ({1'b0, col_q} == cols_eff - 1'b1);
      end
      OP_REDUCE: begin
        ang_q <= ang_red;
      end
      OP_FOLD: begin
        if (ang_fold1 > DEG_QUARTER) begin
          ang_q <= DEG_HALF - ang_fold1;
          neg_q <= 1'b1;
        end else begin
          ang_q <= ang_fold1;
          neg_q <= 1'b0;
        end
      end
      OP_MUL_T: begin
        t_q <= t_prod[62:32];
      end
      OP_MUL_X: begin
        xs_q <= x_prod[61:30];
        h_q  <= ONE_Q30;
        k_q  <= SERIES_TOP;
      end
      OP_MUL_H: begin
        p_q <= h_prod[61:30];
      end
      OP_DIV_H: begin
        hq_q <= 32'(hq_prod >> series_shift(k_q));
      end
      OP_SET_H: begin
        h_q <= (hq_q >= 32'(ONE_Q30)) ? '0 : ONE_Q30 - hq_q[30:0];
        k_q <= k_q - 1'b1;
      end
      OP_EVAL: begin
        cos_q   <= cos_cur;
        su_q    <= su_c;
        sv_q    <= sv_c;
        zero_q  <= (dx_c == 0) || (dy_c == 0) || (geo_q && (csum_c == 0));
        mdx_q   <= dx_c[32] ? 33'(-dx_c) : 33'(dx_c);
        mdy_q   <= dy_c[32] ? 33'(-dy_c) : 33'(dy_c);
        mc_q    <= csum_c[32] ? 32'(-csum_c) : 32'(csum_c);
        dxneg_q <= dx_c[32] ^ (geo_q & csum_c[32]);
        dyneg_q <= dy_c[32];
        den_x_q <= DIV_W'(dx_c[32] ? 33'(-dx_c) : 33'(dx_c));
        den_y_q <= DIV_W'(dy_c[32] ? 33'(-dy_c) : 33'(dy_c));
        curl_q  <= '0;
        sat_q   <= 1'b0;
        xmid_q  <= hx_c[32:1];
        ymid_q  <= hy_c[32:1];
      end
      OP_SCALE1: begin
        p1_q <= 66'(METRES_K) * 66'(mdx_q);
      end
      OP_SCALE2: begin
        den_x_q <= DIV_W'(64'(p1_q[31:0]) * 64'(mc_q));
      end
      OP_SCALE3: begin
        den_x_q <= den_x_q + (DIV_W'(66'(p1_q[65:32]) * 66'(mc_q)) << 32);
      end
      OP_SCALE4: begin
        den_y_q <= DIV_W'(66'(METRES_K) * 66'(mdy_q));
      end
      OP_TERM_SV: begin
        t1_q  <= tval;
        sat_q <= tsat;
      end
      OP_TERM_SU: begin
        t2_q  <= tval;
        sat_q <= sat_q | tsat;
      end
      OP_DIFF: begin
        if (dovf) begin
          curl_q <= t1_q[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
          sat_q  <= 1'b1;
        end else begin
          curl_q <= diff;
        end
      end
      default: begin
      end
    endcase
    if (cmd_i.op == OP_EMIT) begin
      curl_o_q <= curl_q;
      xmid_o_q <= xmid_q;
      ymid_o_q <= ymid_q;
      zero_o_q <= zero_q;
      sat_o_q  <= sat_q;
      last_o_q <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geo_q       <= 1'b0;
      rows_cfg_q  <= ROWS_CFG_W'(2);
      cols_cfg_q  <= COLS_CFG_W'(2);
      row_q       <= '0;
      col_q       <= '0;
      above_u_q   <= '0;
      above_v_q   <= '0;
      above_x_q   <= '0;
      left_u_q    <= '0;
      left_v_q    <= '0;
      prior_y_q   <= '0;
      prior_cos_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (commit) begin
        left_u_q  <= old_u;
        left_v_q  <= old_v;
        above_u_q <= u_q;
        above_v_q <= v_q;
        above_x_q <= x_q;
        if ({1'b0, r_q} + 1'b1 >= rows_eff) begin
          prior_y_q   <= y_q;
          prior_cos_q <= cos_q;
          row_q       <= '0;
          if ({1'b0, col_q} + 1'b1 >= cols_eff) begin
            col_q <= '0;
          end else begin
            col_q <= col_q + 1'b1;
          end
        end else begin
          row_q <= r_q + 1'b1;
        end
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_GEO: begin
            geo_q <= cfg_data_i[0];
          end
          CFG_ROWS: begin
            rows_cfg_q <= cfg_data_i[ROWS_CFG_W-1:0];
            row_q      <= '0;
            col_q      <= '0;
          end
          CFG_COLS: begin
            cols_cfg_q <= cfg_data_i[COLS_CFG_W-1:0];
            row_q      <= '0;
            col_q      <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    status_o.has_result  = has_res_q;
    status_o.zero        = zero_q;
    status_o.geo         = geo_q;
    status_o.div_done    = div_done;
    status_o.series_last = (k_q == 3'd1);
    status_o.out_free    = !out_valid_q || out_ready_i;
  end

  assign out_valid_o    = out_valid_q;
  assign curl_value_o   = curl_o_q;
  assign x_mid_o        = xmid_o_q;
  assign y_mid_o        = ymid_o_q;
  assign zero_spacing_o = zero_o_q;
  assign saturated_o    = sat_o_q;
  assign last_of_grid_o = last_o_q;

endmodule

`default_nettype wire

### hw/rtl/curl_grid_box_centered.sv
// A point with no box frees the input without producing an output; a box is written
// to the output register once that register is free (geographic mode adds the scaling
// steps first), and the controller then returns to idle so the next point can transfer.
// The shared bit-serial divider runs 128 steps for each curl term; the seven cosine
// series terms are each evaluated with a multiply, a reciprocal multiply and an update.
// Reset clears the configuration (plain mode, 2 by 2 grid), the counters, the
// held neighbor values and the output valid; the line buffer is not cleared.
`default_nettype none

module curl_grid_box_centered (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cgbc_in_if.sink    in_ch,
  cgbc_out_if.source out_ch,
  cgbc_cfg_if.sink   cfg_ch
);
  import cgbc_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ch.ready = 1'b1;

  cgbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cgbc_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .u_value_i      (in_ch.u_value),
    .v_value_i      (in_ch.v_value),
    .x_coord_i      (in_ch.x_coord),
    .y_coord_i      (in_ch.y_coord),
    .cfg_valid_i    (cfg_ch.valid),
    .cfg_index_i    (cfg_ch.index),
    .cfg_data_i     (cfg_ch.data),
    .out_valid_o    (out_ch.valid),
    .out_ready_i    (out_ch.ready),
    .curl_value_o   (out_ch.curl_value),
    .x_mid_o        (out_ch.x_mid),
    .y_mid_o        (out_ch.y_mid),
    .zero_spacing_o (out_ch.zero_spacing),
    .saturated_o    (out_ch.saturated),
    .last_of_grid_o (out_ch.last_of_grid)
  );

endmodule

`default_nettype wire

### hw/rtl/cgbc_checker.sv
// Port-level checks for the curl block and the bind that attaches them.
// Depends on curl_grid_box_centered and its channel interfaces.
`default_nettype none

module cgbc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [63:0] curl_value_i,
  input wire logic        zero_spacing_i,
  input wire logic        saturated_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("Output valid dropped before its transfer.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(curl_value_i))
    else $error("Curl changed while the output was stalled.");

  a_zero_curl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && zero_spacing_i |-> curl_value_i == 64'd0 && !saturated_i)
    else $error("Zero spacing reported with a nonzero curl or saturation.");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("A new point was taken while one was in work.");

endmodule

bind curl_grid_box_centered cgbc_checker u_cgbc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_ch.valid),
  .in_ready_i     (in_ch.ready),
  .out_valid_i    (out_ch.valid),
  .out_ready_i    (out_ch.ready),
  .curl_value_i   (out_ch.curl_value),
  .zero_spacing_i (out_ch.zero_spacing),
  .saturated_i    (out_ch.saturated)
);

`default_nettype wire
